// ----- hw/rtl/sspc_pkg.sv -----
package sspc_pkg;

   localparam int MEM_WORDS = 65536;
   localparam int MEM_AW    = $clog2(MEM_WORDS);

   localparam logic [4:0] OP_ADD = 5'd0;
   localparam logic [4:0] OP_SUB = 5'd1;
   localparam logic [4:0] OP_LSF = 5'd2;
   localparam logic [4:0] OP_RSF = 5'd3;
   localparam logic [4:0] OP_AND = 5'd4;
   localparam logic [4:0] OP_OR  = 5'd5;
   localparam logic [4:0] OP_XOR = 5'd6;
   localparam logic [4:0] OP_LHI = 5'd7;
   localparam logic [4:0] OP_LD  = 5'd8;
   localparam logic [4:0] OP_ST  = 5'd9;
   localparam logic [4:0] OP_JLT = 5'd16;
   localparam logic [4:0] OP_JLE = 5'd17;
   localparam logic [4:0] OP_JEQ = 5'd18;
   localparam logic [4:0] OP_JNE = 5'd19;
   localparam logic [4:0] OP_JIN = 5'd20;
   localparam logic [4:0] OP_HLT = 5'd24;

   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_TICK = 2'd1;
   localparam logic [1:0] MODE_READ = 2'd2;
   localparam logic [1:0] MODE_IDLE = 2'd3;

   localparam logic [2:0] REG_ZERO = 3'd0;
   localparam logic [2:0] REG_IMM  = 3'd1;
   localparam logic [2:0] REG_LINK = 3'd7;

   typedef struct packed {
      logic        en;
      logic [2:0]  addr;
      logic [31:0] data;
   } rf_wr_type;

   function automatic logic is_alu_op(input logic [4:0] op);
      return op <= OP_LHI;
   endfunction

   function automatic logic is_jump_op(input logic [4:0] op);
      return (op >= OP_JLT) && (op <= OP_JIN);
   endfunction

endpackage

// ----- hw/rtl/six_stage_pipelined_cpu.sv -----
// channel | dir | ports                                          | word
// req     | in  | req_valid req_stall req_mode req_mem_address   | one command
//         |     | req_mem_data                                   |
// rsp     | out | rsp_valid rsp_stall rsp_read_data rsp_retired_* | one status
//         |     | rsp_halted rsp_cycle_count                     |
// One command word per clock while req_stall is low; each accepted word is one
// processor tick (or a memory load/read) and yields one status word, registered
// in s1 and the output register; memory ports (one read, one write each) set the rate.
// Synchronous reset clears pipeline control and the register file, not the memories.
// A status word waits in the output register; req_stall rises only when both
// the output register and the stage behind it are full and rsp_stall is high.
module six_stage_pipelined_cpu import sspc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_mem_address,
   input  logic [31:0] req_mem_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_read_data,
   output logic        rsp_retired_valid,
   output logic [15:0] rsp_retired_pc,
   output logic [4:0]  rsp_retired_opcode,
   output logic        rsp_halted,
   output logic [31:0] rsp_cycle_count
);

   // pipeline state
   logic [5:0]  v_ff, v_in;
   logic [15:0] pc_ff [6];
   logic [15:0] pc_in [6];
   logic [31:0] d0_inst_ff;
   logic [4:0]  d1_op_ff;
   logic [2:0]  d1_dst_ff, d1_s0_ff, d1_s1_ff;
   logic [15:0] d1_imm_ff;
   logic [4:0]  e0_op_ff;
   logic [2:0]  e0_dst_ff;
   logic [15:0] e0_imm_ff;
   logic [31:0] e0_a0_ff, e0_a1_ff, e0_a0_in, e0_a1_in;
   logic [4:0]  e1_op_ff;
   logic [2:0]  e1_dst_ff;
   logic [15:0] e1_imm_ff;
   logic [31:0] e1_a0_ff, e1_a1_ff, e1_out_ff;
   logic [31:0] cyc_ff, cyc_in;
   logic        halt_ff, halt_in;
   // load data lives in the dmem read register until another read displaces it
   logic [31:0] dro_ff;
   logic        dro_q_ff, dro_q_in;
   logic [31:0] dro;

   // response path: s1 waits for dmem read data, out is the output register
   logic        s1_v_ff, s1_rd_ff, s1_rv_ff, s1_halt_ff;
   logic [15:0] s1_pc_ff;
   logic [4:0]  s1_op_ff;
   logic [31:0] s1_cyc_ff;
   logic        out_v_ff;
   logic [31:0] out_rd_ff;
   logic        out_rv_ff, out_halt_ff;
   logic [15:0] out_pc_ff;
   logic [4:0]  out_op_ff;
   logic [31:0] out_cyc_ff;

   logic        accept, tick, s1_adv;
   logic        jmp_taken;
   logic [31:0] imm_ext;
   logic [31:0] imem_q, dmem_q;
   logic        dmem_we, dmem_re, ld_issue;
   logic [MEM_AW-1:0] dmem_wa, dmem_ra;
   logic [31:0] dmem_wd;
   logic [31:0] rq0, rq1;
   logic [2:0]  ra0;
   rf_wr_type   rf_wr;
   logic [31:0] alu_res;
   logic        alu_ok;

   assign s1_adv    = s1_v_ff && (!out_v_ff || !rsp_stall);
   assign req_stall = s1_v_ff && out_v_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign tick      = accept && req_mode == MODE_TICK && !halt_ff;

   assign imm_ext   = {{16{d1_imm_ff[15]}}, d1_imm_ff};
   assign dro       = dro_q_ff ? dmem_q : dro_ff;
   assign jmp_taken = v_ff[5] && is_jump_op(e1_op_ff) && e1_out_ff == 32'd1;

   // ---------------- memories ----------------
   sspc_ram #(.AW(MEM_AW), .DW(32)) u_imem (
      .clock (clock),
      .we    (accept && req_mode == MODE_LOAD),
      .waddr (req_mem_address[MEM_AW-1:0]),
      .wdata (req_mem_data),
      .re    (tick && v_ff[0]),
      .raddr (pc_ff[0][MEM_AW-1:0]),
      .rdata (imem_q)
   );

   assign ld_issue = tick && v_ff[4] && e0_op_ff == OP_LD;
   assign dmem_re  = (accept && req_mode == MODE_READ) || ld_issue;
   assign dmem_ra  = ld_issue ? e0_a1_ff[MEM_AW-1:0] : req_mem_address[MEM_AW-1:0];
   assign dmem_we  = (accept && req_mode == MODE_LOAD)
                     || (tick && v_ff[5] && e1_op_ff == OP_ST);
   assign dmem_wa  = (req_mode == MODE_LOAD) ? req_mem_address[MEM_AW-1:0]
                                             : e1_a1_ff[MEM_AW-1:0];
   assign dmem_wd  = (req_mode == MODE_LOAD) ? req_mem_data : e1_a0_ff;

   sspc_ram #(.AW(MEM_AW), .DW(32)) u_dmem (
      .clock (clock),
      .we    (dmem_we),
      .waddr (dmem_wa),
      .wdata (dmem_wd),
      .re    (dmem_re),
      .raddr (dmem_ra),
      .rdata (dmem_q)
   );

   // ---------------- register file ----------------
   // read in dec0 so the data is registered for dec1; exec1 writes forward through
   assign ra0 = (d0_inst_ff[29:25] == OP_LHI) ? d0_inst_ff[24:22] : d0_inst_ff[21:19];

   always_comb begin
      rf_wr = '0;
      if (tick && v_ff[5]) begin
         if (is_alu_op(e1_op_ff)) begin
            rf_wr = '{en: 1'b1, addr: e1_dst_ff, data: e1_out_ff};
         end else if (e1_op_ff == OP_LD) begin
            rf_wr = '{en: 1'b1, addr: e1_dst_ff, data: dro};
         end else if (jmp_taken) begin
            rf_wr = '{en: 1'b1, addr: REG_LINK, data: {16'd0, pc_ff[5]}};
         end
      end
   end

   sspc_rf u_rf (
      .clock (clock),
      .reset (reset),
      .re    (tick && v_ff[2]),
      .ra0   (ra0),
      .ra1   (d0_inst_ff[18:16]),
      .wr    (rf_wr),
      .rq0   (rq0),
      .rq1   (rq1)
   );

   // ---------------- dec1 operand select with exec1 bypass ----------------
   function automatic logic [31:0] operand(input logic [2:0] src, input logic [31:0] rq);
      logic [31:0] r;
      r = rq;
      if (src == REG_ZERO) begin
         r = '0;
      end else if (src == REG_IMM) begin
         r = imm_ext;
      end else if (v_ff[5] && e1_dst_ff == src && is_alu_op(e1_op_ff)) begin
         r = e1_out_ff;
      end else if (v_ff[5] && e1_op_ff == OP_LD && e1_dst_ff == src) begin
         r = dro;
      end else if (jmp_taken && src == REG_LINK) begin
         r = {16'd0, pc_ff[5]};
      end
      return r;
   endfunction

   always_comb begin
      if (d1_op_ff == OP_LHI) begin
         e0_a0_in = {16'd0, rq0[15:0]};
         e0_a1_in = imm_ext;
      end else begin
         e0_a0_in = operand(d1_s0_ff, rq0);
         e0_a1_in = operand(d1_s1_ff, rq1);
      end
   end

   sspc_alu u_alu (
      .op  (e0_op_ff),
      .a   (e0_a0_ff),
      .b   (e0_a1_ff),
      .res (alu_res),
      .ok  (alu_ok)
   );

   // ---------------- next-state for one tick ----------------
   always_comb begin
      v_in     = v_ff;
      pc_in    = pc_ff;
      cyc_in   = cyc_ff;
      halt_in  = halt_ff;
      dro_q_in = dmem_re ? ld_issue : dro_q_ff;
      if (tick) begin
         cyc_in  = cyc_ff + 32'd1;
         v_in[0] = 1'b1;
         v_in[1] = v_ff[0];
         v_in[5:2] = v_ff[4:1];
         if (v_ff[0]) begin
            pc_in[0] = pc_ff[0] + 16'd1;
            pc_in[1] = pc_ff[0];
         end
         for (int s = 2; s < 6; s++) begin
            if (v_ff[s-1]) begin
               pc_in[s] = pc_ff[s-1];
            end
         end
         if (jmp_taken) begin
            pc_in[0] = e1_imm_ff;
         end
         if (v_ff[5] && e1_op_ff == OP_HLT) begin
            halt_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff     <= '0;
         cyc_ff   <= '0;
         halt_ff  <= 1'b0;
         dro_q_ff <= 1'b0;
         dro_ff   <= '0;
         for (int s = 0; s < 6; s++) begin
            pc_ff[s] <= '0;
         end
      end else begin
         v_ff     <= v_in;
         pc_ff    <= pc_in;
         cyc_ff   <= cyc_in;
         halt_ff  <= halt_in;
         dro_q_ff <= dro_q_in;
         if (dro_q_ff) begin
            dro_ff <= dmem_q;
         end
      end
   end

   // stage payload; idle stages keep their fields
   always_ff @(posedge clock) begin
      if (tick) begin
         if (v_ff[1]) begin
            d0_inst_ff <= imem_q;
         end
         if (v_ff[2]) begin
            d1_op_ff  <= d0_inst_ff[29:25];
            d1_dst_ff <= d0_inst_ff[24:22];
            d1_s0_ff  <= d0_inst_ff[21:19];
            d1_s1_ff  <= d0_inst_ff[18:16];
            d1_imm_ff <= d0_inst_ff[15:0];
         end
         if (v_ff[3]) begin
            e0_op_ff  <= d1_op_ff;
            e0_dst_ff <= d1_dst_ff;
            e0_imm_ff <= d1_imm_ff;
            e0_a0_ff  <= e0_a0_in;
            e0_a1_ff  <= e0_a1_in;
         end
         if (v_ff[4]) begin
            if (alu_ok) begin
               e1_out_ff <= alu_res;
            end
            e1_op_ff  <= e0_op_ff;
            e1_dst_ff <= e0_dst_ff;
            e1_imm_ff <= e0_imm_ff;
            e1_a0_ff  <= e0_a0_ff;
            e1_a1_ff  <= e0_a1_ff;
         end
      end
   end

   // ---------------- response path ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_v_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_v_ff <= 1'b0;
         end
         if (s1_adv) begin
            out_v_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_rd_ff   <= req_mode == MODE_READ;
         s1_rv_ff   <= tick && v_ff[5];
         s1_pc_ff   <= (tick && v_ff[5]) ? pc_ff[5] : 16'd0;
         s1_op_ff   <= (tick && v_ff[5]) ? e1_op_ff : 5'd0;
         s1_halt_ff <= halt_in;
         s1_cyc_ff  <= cyc_in;
      end
      if (s1_adv) begin
         out_rd_ff   <= s1_rd_ff ? dmem_q : 32'd0;
         out_rv_ff   <= s1_rv_ff;
         out_pc_ff   <= s1_pc_ff;
         out_op_ff   <= s1_op_ff;
         out_halt_ff <= s1_halt_ff;
         out_cyc_ff  <= s1_cyc_ff;
      end
   end

   assign rsp_valid          = out_v_ff;
   assign rsp_read_data      = out_rd_ff;
   assign rsp_retired_valid  = out_rv_ff;
   assign rsp_retired_pc     = out_pc_ff;
   assign rsp_retired_opcode = out_op_ff;
   assign rsp_halted         = out_halt_ff;
   assign rsp_cycle_count    = out_cyc_ff;

endmodule

// ----- hw/rtl/sspc_ram.sv -----
module sspc_ram #(
   parameter int AW = 16,
   parameter int DW = 32
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem [2**AW];

   // read-first: a read and a write of one word in one cycle return the old word
   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem[raddr];
      end
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

endmodule

// ----- hw/rtl/sspc_rf.sv -----
module sspc_rf import sspc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        re,
   input  logic [2:0]  ra0,
   input  logic [2:0]  ra1,
   input  rf_wr_type   wr,
   output logic [31:0] rq0,
   output logic [31:0] rq1
);

   logic [31:0] regs_ff [8];

   // write-through on the read ports: a read in the writing cycle sees the new value
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            regs_ff[i] <= '0;
         end
      end else if (wr.en) begin
         regs_ff[wr.addr] <= wr.data;
      end
      if (re) begin
         rq0 <= (wr.en && wr.addr == ra0) ? wr.data : regs_ff[ra0];
         rq1 <= (wr.en && wr.addr == ra1) ? wr.data : regs_ff[ra1];
      end
   end

endmodule

// ----- hw/rtl/sspc_alu.sv -----
module sspc_alu import sspc_pkg::*; (
   input  logic [4:0]  op,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] res,
   output logic        ok
);

   logic lt;
   logic big;

   always_comb begin
      lt  = $signed(a) < $signed(b);
      big = b >= 32'd32;
      ok  = 1'b1;
      res = '0;
      case (op)
         OP_ADD: res = a + b;
         OP_SUB: res = a - b;
         OP_LSF: res = big ? 32'd0 : (a << b[4:0]);
         OP_RSF: res = big ? {32{a[31]}} : 32'($signed(a) >>> b[4:0]);
         OP_AND: res = a & b;
         OP_OR:  res = a | b;
         OP_XOR: res = a ^ b;
         OP_LHI: res = {b[15:0], a[15:0]};
         OP_JLT: res = {31'd0, lt};
         OP_JLE: res = {31'd0, lt || (a == b)};
         OP_JEQ: res = {31'd0, a == b};
         OP_JNE: res = {31'd0, a != b};
         OP_JIN: res = 32'd1;
         default: ok = 1'b0;
      endcase
   end

endmodule
